// ----- hw/rtl/sflx_pkg.sv -----
package sflx_pkg;

	// Result kinds.
	localparam logic [1:0] KIND_TX      = 2'd0;
	localparam logic [1:0] KIND_AUDIO   = 2'd1;
	localparam logic [1:0] KIND_RELAY   = 2'd2;
	localparam logic [1:0] KIND_VERDICT = 2'd3;

	// Receive verdicts.
	localparam logic [1:0] VERD_REJECT = 2'd0;
	localparam logic [1:0] VERD_AUDIO  = 2'd1;
	localparam logic [1:0] VERD_TEXT   = 2'd2;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_DUP_WINDOW       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_SEND_COPIES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RELAY_COPIES     = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [7:0] DUP_WINDOW_RST = 8'd100;
	localparam logic [3:0] TEXT_COPIES_RST = 4'd2;
	localparam logic [3:0] RELAY_COPIES_RST = 4'd10;

	// Seed of the XOR checksum and of the last accepted ids.
	localparam logic [7:0] CHECK_SEED = 8'd1;
	localparam logic [7:0] LAST_ID_RST = 8'd1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_EMIT_ID,
		ST_EMIT_TYPE,
		ST_EMIT_TXB,
		ST_PAY_RD,
		ST_PAY_OUT,
		ST_EMIT_VERD
	} state_t;

	// What the item held in the datapath calls for.
	typedef enum logic [2:0] {
		CLS_NONE,
		CLS_TX_FIRST,
		CLS_TX_BYTE,
		CLS_AUDIO_OK,
		CLS_TEXT_OK,
		CLS_REJECT
	} cls_t;

	// Source of the next result beat.
	typedef enum logic [2:0] {
		SEL_ID,
		SEL_TYPE,
		SEL_TXB_NOW,
		SEL_TXB,
		SEL_PAY,
		SEL_VERD
	} sel_t;

	typedef struct packed {
		logic in_ready;
		logic decide;
		logic load;
		sel_t sel;
		logic last;
		logic rd;
		logic idx_clr;
		logic idx_inc;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_fire;
		cls_t cls;
		logic can_load;
		logic idx_last;
		logic relay;
	} ctl_sts_t;

	// A copy count written as zero is reported as one.
	function automatic logic [3:0] copies_of(input logic [3:0] reg_val);
		return (reg_val == 4'd0) ? 4'd1 : reg_val;
	endfunction

	// An id is new if it is ahead of the last one or behind it by more than the window.
	function automatic logic id_is_new(input logic [7:0] id, input logic [7:0] last,
		input logic [7:0] win);
		logic [7:0] id_gap;
		id_gap = last - id;
		return (id > last) || (id_gap > win);
	endfunction

endpackage

// ----- hw/rtl/sflx_if.sv -----
interface sflx_in_if;
	logic       valid;
	logic       ready;
	logic       opcode;
	logic       frame_kind;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source(output valid, opcode, frame_kind, data_byte, first_byte, input ready);
	modport sink(input valid, opcode, frame_kind, data_byte, first_byte, output ready);
endinterface

interface sflx_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] result_kind;
	logic [3:0] copies;
	logic [1:0] verdict;
	logic       end_of_run;

	modport source(output valid, out_byte, result_kind, copies, verdict, end_of_run,
		input ready);
	modport sink(input valid, out_byte, result_kind, copies, verdict, end_of_run,
		output ready);
endinterface

interface sflx_cfg_if import sflx_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [7:0]           data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- hw/rtl/sequenced_frame_link_with_xor_check.sv -----
// A mid-frame transmit beat is loaded into the output register in the decide state, or in
// the transmit beat state if the result side stalls; a first transmit byte gives id, type
// and transmit beats, a rejected frame a verdict beat, and an accepted frame payload beats
// (read, then beat), after id and type beats for a relay; other receive bytes and dropped
// bytes give no beat. A new item is taken only once all beats of the last are loaded.
// Reset is asynchronous and clears control state; the payload memory is not cleared.
module sequenced_frame_link_with_xor_check import sflx_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	sflx_in_if.sink    item,
	sflx_out_if.source result,
	sflx_cfg_if.sink   cfg
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	sflx_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	sflx_datapath #(
		.PAYLOAD_BYTES (PAYLOAD_BYTES)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg),
		.cmd    (cmd),
		.sts    (sts)
	);

endmodule

// ----- hw/rtl/sflx_datapath.sv -----
module sflx_datapath import sflx_pkg::*; #(
	parameter int unsigned PAYLOAD_BYTES = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	sflx_in_if.sink    item,
	sflx_out_if.source result,
	sflx_cfg_if.sink   cfg,
	input  ctl_cmd_t   cmd,
	output ctl_sts_t   sts
);

	localparam int unsigned PosW = $clog2(PAYLOAD_BYTES + 2);
	localparam int unsigned IdxW = $clog2(PAYLOAD_BYTES);
	localparam logic [PosW-1:0] TxLast = PosW'(PAYLOAD_BYTES - 1);
	localparam logic [PosW-1:0] RxLast = PosW'(PAYLOAD_BYTES + 1);
	localparam logic [IdxW-1:0] IdxLast = IdxW'(PAYLOAD_BYTES - 1);

	// Configuration registers.
	logic [7:0] dup_window_q;
	logic [3:0] text_copies_q;
	logic [3:0] relay_copies_q;

	// Latched input item.
	logic       op_q;
	logic       kind_q;
	logic [7:0] byte_q;
	logic       first_q;

	// Link state.
	logic [7:0]      audio_last_q;
	logic [7:0]      text_last_q;
	logic [PosW-1:0] pos_q;
	logic [7:0]      chk_q;
	logic [7:0]      id_q;
	logic [7:0]      type_q;
	logic            open_q;
	logic            rx_q;
	logic [1:0]      mode_q;
	logic [7:0]      txb_q;

	// Payload store and its read side.
	logic [7:0]      pay_mem_q [PAYLOAD_BYTES];
	logic [7:0]      rdata_q;
	logic [IdxW-1:0] idx_q;

	// Output register.
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic [1:0] out_kind_q;
	logic [3:0] out_copies_q;
	logic [1:0] out_verdict_q;
	logic       out_end_q;

	logic [PosW-1:0] p_eff;
	logic [7:0]      chk_eff;
	logic            tx_ok;
	logic            rx_ok;
	logic            tx_mid;
	logic            type_text;
	logic [7:0]      tx_ob;
	logic            audio_new;
	logic            text_new;
	cls_t            cls;
	logic [3:0]      tx_copies;
	logic [3:0]      rl_copies;
	logic [IdxW-1:0] waddr;
	logic [7:0]      nx_byte;
	logic [1:0]      nx_kind;
	logic [3:0]      nx_copies;
	logic [1:0]      nx_verdict;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dup_window_q   <= DUP_WINDOW_RST;
			text_copies_q  <= TEXT_COPIES_RST;
			relay_copies_q <= RELAY_COPIES_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_DUP_WINDOW:       dup_window_q <= cfg.data;
				REG_TEXT_SEND_COPIES: text_copies_q <= cfg.data[3:0];
				REG_RELAY_COPIES:     relay_copies_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	// Input handshake and item capture.
	assign item.ready  = cmd.in_ready;
	assign sts.in_fire = item.valid && cmd.in_ready;

	always_ff @(posedge clk) begin
		if (sts.in_fire) begin
			op_q    <= item.opcode;
			kind_q  <= item.frame_kind;
			byte_q  <= item.data_byte;
			first_q <= item.first_byte;
		end
	end

	// Classify the held item against the current link state.
	always_comb begin
		p_eff     = first_q ? '0 : pos_q;
		chk_eff   = first_q ? CHECK_SEED : chk_q;
		tx_ok     = first_q || (open_q && !rx_q);
		rx_ok     = first_q || (open_q && rx_q);
		tx_mid    = p_eff < TxLast;
		type_text = first_q ? kind_q : (type_q != 8'd0);
		tx_ob     = (tx_mid || !type_text) ? byte_q : chk_eff;
		audio_new = id_is_new(id_q, audio_last_q, dup_window_q);
		text_new  = id_is_new(id_q, text_last_q, dup_window_q);
		if (!op_q) begin
			if (!tx_ok) begin
				cls = CLS_NONE;
			end else begin
				cls = first_q ? CLS_TX_FIRST : CLS_TX_BYTE;
			end
		end else if (!rx_ok || p_eff != RxLast) begin
			cls = CLS_NONE;
		end else if (type_q == 8'd0) begin
			cls = audio_new ? CLS_AUDIO_OK : CLS_REJECT;
		end else begin
			cls = (text_new && byte_q == chk_eff) ? CLS_TEXT_OK : CLS_REJECT;
		end
	end

	assign sts.cls = cls;

	// State update when the held item is processed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			audio_last_q <= LAST_ID_RST;
			text_last_q  <= LAST_ID_RST;
			pos_q        <= '0;
			chk_q        <= CHECK_SEED;
			id_q         <= 8'd0;
			type_q       <= 8'd0;
			open_q       <= 1'b0;
			rx_q         <= 1'b0;
			mode_q       <= KIND_TX;
		end else if (cmd.decide) begin
			if (!op_q && tx_ok) begin
				if (first_q) begin
					type_q <= {7'd0, kind_q};
					if (kind_q) begin
						text_last_q <= text_last_q + 8'd1;
						id_q        <= text_last_q + 8'd1;
					end else begin
						audio_last_q <= audio_last_q + 8'd1;
						id_q         <= audio_last_q + 8'd1;
					end
				end
				pos_q  <= p_eff + PosW'(1);
				chk_q  <= tx_mid ? (chk_eff ^ byte_q) : chk_eff;
				open_q <= tx_mid;
				rx_q   <= 1'b0;
				mode_q <= KIND_TX;
			end else if (op_q && rx_ok) begin
				if (p_eff == PosW'(0)) begin
					id_q <= byte_q;
				end else if (p_eff == PosW'(1)) begin
					type_q <= byte_q;
				end
				if (p_eff >= PosW'(2) && p_eff < RxLast) begin
					chk_q <= chk_eff ^ byte_q;
				end else begin
					chk_q <= chk_eff;
				end
				pos_q  <= p_eff + PosW'(1);
				open_q <= (p_eff != RxLast);
				rx_q   <= 1'b1;
				if (cls == CLS_AUDIO_OK) begin
					audio_last_q <= id_q;
					mode_q       <= KIND_AUDIO;
				end else if (cls == CLS_TEXT_OK) begin
					text_last_q <= id_q;
					mode_q      <= KIND_RELAY;
				end
			end
		end
	end

	// Held copy of the transmit byte for the end of a header sequence or a stalled transmit beat.
	always_ff @(posedge clk) begin
		if (cmd.decide) begin
			txb_q <= tx_ob;
		end
	end

	// Payload store: written by receive bytes, read one byte per request.
	assign waddr = IdxW'(p_eff - PosW'(2));

	always_ff @(posedge clk) begin
		if (cmd.decide && op_q && rx_ok && p_eff >= PosW'(2)) begin
			pay_mem_q[waddr] <= byte_q;
		end
		if (cmd.rd) begin
			rdata_q <= pay_mem_q[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + IdxW'(1);
		end
	end

	assign sts.idx_last = (idx_q == IdxLast);
	assign sts.relay    = (mode_q == KIND_RELAY);

	// Result field selection.
	always_comb begin
		tx_copies = (type_q != 8'd0) ? copies_of(text_copies_q) : 4'd1;
		rl_copies = copies_of(relay_copies_q);
		case (cmd.sel)
			SEL_ID, SEL_TYPE: begin
				nx_byte    = (cmd.sel == SEL_ID) ? id_q : type_q;
				nx_kind    = mode_q;
				nx_copies  = (mode_q == KIND_RELAY) ? rl_copies : tx_copies;
				nx_verdict = (mode_q == KIND_RELAY) ? VERD_TEXT : VERD_REJECT;
			end
			SEL_TXB_NOW, SEL_TXB: begin
				nx_byte    = (cmd.sel == SEL_TXB_NOW) ? tx_ob : txb_q;
				nx_kind    = KIND_TX;
				nx_copies  = tx_copies;
				nx_verdict = VERD_REJECT;
			end
			SEL_PAY: begin
				nx_byte    = (mode_q == KIND_RELAY && sts.idx_last) ? 8'd0 : rdata_q;
				nx_kind    = mode_q;
				nx_copies  = (mode_q == KIND_RELAY) ? rl_copies : 4'd0;
				nx_verdict = (mode_q == KIND_RELAY) ? VERD_TEXT : VERD_AUDIO;
			end
			default: begin
				nx_byte    = 8'd0;
				nx_kind    = KIND_VERDICT;
				nx_copies  = 4'd0;
				nx_verdict = VERD_REJECT;
			end
		endcase
	end

	// Output register.
	assign sts.can_load = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_byte_q    <= nx_byte;
			out_kind_q    <= nx_kind;
			out_copies_q  <= nx_copies;
			out_verdict_q <= nx_verdict;
			out_end_q     <= cmd.last;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.out_byte    = out_byte_q;
	assign result.result_kind = out_kind_q;
	assign result.copies      = out_copies_q;
	assign result.verdict     = out_verdict_q;
	assign result.end_of_run  = out_end_q;

`ifndef SYNTHESIS
	// A beat waiting in the output register is never overwritten.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> (!out_valid_q || result.ready))
		else $error("result beat overwritten");

	// A beat that is not taken stays offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |=> out_valid_q)
		else $error("result beat dropped");

	// An open frame never runs past its last byte position.
	assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> (pos_q <= RxLast))
		else $error("byte position beyond frame end");
`endif

endmodule

// ----- hw/rtl/sflx_ctrl.sv -----
module sflx_ctrl import sflx_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_fire) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				case (sts.cls)
					CLS_TX_FIRST, CLS_TEXT_OK: state_d = ST_EMIT_ID;
					CLS_TX_BYTE: state_d = sts.can_load ? ST_IDLE : ST_EMIT_TXB;
					CLS_AUDIO_OK: state_d = ST_PAY_RD;
					CLS_REJECT: state_d = ST_EMIT_VERD;
					default: state_d = ST_IDLE;
				endcase
			end
			ST_EMIT_ID: begin
				if (sts.can_load) state_d = ST_EMIT_TYPE;
			end
			ST_EMIT_TYPE: begin
				if (sts.can_load) state_d = sts.relay ? ST_PAY_RD : ST_EMIT_TXB;
			end
			ST_EMIT_TXB, ST_EMIT_VERD: begin
				if (sts.can_load) state_d = ST_IDLE;
			end
			ST_PAY_RD: begin
				state_d = ST_PAY_OUT;
			end
			ST_PAY_OUT: begin
				if (sts.can_load) state_d = sts.idx_last ? ST_IDLE : ST_PAY_RD;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '{in_ready: 1'b0, decide: 1'b0, load: 1'b0, sel: SEL_VERD, last: 1'b0,
			rd: 1'b0, idx_clr: 1'b0, idx_inc: 1'b0};
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			ST_DECIDE: begin
				cmd.decide  = 1'b1;
				cmd.idx_clr = 1'b1;
				cmd.sel     = SEL_TXB_NOW;
				cmd.last    = 1'b1;
				cmd.load    = (sts.cls == CLS_TX_BYTE) && sts.can_load;
			end
			ST_EMIT_ID: begin
				cmd.sel  = SEL_ID;
				cmd.load = sts.can_load;
			end
			ST_EMIT_TYPE: begin
				cmd.sel  = SEL_TYPE;
				cmd.load = sts.can_load;
			end
			ST_EMIT_TXB: begin
				cmd.sel  = SEL_TXB;
				cmd.last = 1'b1;
				cmd.load = sts.can_load;
			end
			ST_PAY_RD: begin
				cmd.rd = 1'b1;
			end
			ST_PAY_OUT: begin
				cmd.sel     = SEL_PAY;
				cmd.last    = sts.idx_last;
				cmd.load    = sts.can_load;
				cmd.idx_inc = sts.can_load;
			end
			ST_EMIT_VERD: begin
				cmd.sel  = SEL_VERD;
				cmd.last = 1'b1;
				cmd.load = sts.can_load;
			end
			default: ;
		endcase
	end

`ifndef SYNTHESIS
	// An accepted item is processed in the very next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		sts.in_fire |=> (state_q == ST_DECIDE))
		else $error("accepted item not processed");

	// A payload read is always followed by its output beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAY_RD) |=> (state_q == ST_PAY_OUT))
		else $error("payload read without beat");

	// The last payload beat ends the run and frees the input.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PAY_OUT && cmd.load && sts.idx_last) |=> (state_q == ST_IDLE))
		else $error("payload run did not end");
`endif

endmodule
